// ===== design/ise_pkg.sv =====
package ise_pkg;

  localparam int KEY_W   = 32;
  localparam int IDXIN_W = 10;
  localparam int HI_W    = 11;
  localparam int IDX_W   = 12;
  localparam int SPAN_W  = 10;
  localparam int CNT_W   = 11;

  localparam logic FUNC_WRITE  = 1'b0;
  localparam logic FUNC_SEARCH = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_LO,
    ST_RD_HI,
    ST_CHK,
    ST_DIV,
    ST_RD_POS,
    ST_CMP,
    ST_FIN
  } state_t;

endpackage

// ===== design/ise_ram.sv =====
module ise_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== design/ise_muldiv.sv =====
module ise_muldiv
  import ise_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [KEY_W-1:0]  num,
  input  logic [SPAN_W-1:0] span,
  input  logic [KEY_W-1:0]  den_in,
  output logic              busy,
  output logic [SPAN_W-1:0] quot
);

  localparam int CW = $clog2(SPAN_W);

  logic [KEY_W-1:0]        rem;
  logic [KEY_W-1:0]        den;
  logic [SPAN_W-1:0]       shreg;
  logic [CW-1:0]           cnt;
  logic [KEY_W+SPAN_W-1:0] prod;
  logic [KEY_W:0]          trial;
  logic [KEY_W:0]          diff;
  logic                    ge;

  // quotient never exceeds span, so only SPAN_W long-division steps are needed
  assign prod  = {{SPAN_W{1'b0}}, num} * {{KEY_W{1'b0}}, span};
  assign trial = {rem, shreg[SPAN_W-1]};
  assign diff  = trial - {1'b0, den};
  assign ge    = (trial >= {1'b0, den});
  assign quot  = shreg;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + CW'(1);
      if (cnt == CW'(SPAN_W - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      {rem, shreg} <= prod;
      den          <= den_in;
    end else if (busy) begin
      rem   <= ge ? diff[KEY_W-1:0] : trial[KEY_W-1:0];
      shreg <= {shreg[SPAN_W-2:0], ge};
    end
  end

endmodule

// ===== design/interpolation_search_engine.sv =====
// Interpolation search over an on-chip array of signed 32-bit values that
// software writes in ascending order. A write item (func 0) gives no
// result; a search item (func 1) gives one result with found, found_index
// and probe_count. The array sits in a single-port RAM with registered
// read, so each probe reads A[lo], A[hi] and A[pos] one after another. The
// probe position comes from a single multiply and restoring-divide unit
// (one multiply, then ten quotient bits); when both end values are equal
// the unit is skipped and the probe goes to lo. A last read of the end
// values can stop the search without a probe, and an empty range goes
// straight to the result. The input is stalled for the whole search; a
// finished result waits in the output register while the next item is
// taken.
module interpolation_search_engine
  import ise_pkg::*;
#(
  parameter int DEPTH = 1024
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      func,
  input  logic [IDXIN_W-1:0]        entry_index,
  input  logic signed [KEY_W-1:0]   entry_value,
  input  logic signed [KEY_W-1:0]   search_key,
  input  logic [IDXIN_W-1:0]        range_low,
  input  logic signed [HI_W-1:0]    range_high,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      found,
  output logic [IDXIN_W-1:0]        found_index,
  output logic [CNT_W-1:0]          probe_count
);

  localparam int AW      = $clog2(DEPTH);
  localparam int MAX_IDX = (DEPTH - 1 < 1023) ? DEPTH - 1 : 1023;
  localparam logic signed [IDX_W-1:0] HI_MAX = IDX_W'(MAX_IDX);

  state_t state, state_next;

  logic signed [KEY_W-1:0] key, key_next;
  logic signed [KEY_W-1:0] a_lo, a_lo_next;
  logic signed [IDX_W-1:0] lo, lo_next;
  logic signed [IDX_W-1:0] hi, hi_next;
  logic signed [IDX_W-1:0] pos, pos_next;
  logic                    hit, hit_next;
  logic [CNT_W-1:0]        probes, probes_next;

  logic signed [IDX_W-1:0] lo_in, hi_in, hi_cl, lo2, hi2;
  logic                    accept;
  logic                    out_load;
  logic                    mem_we;
  logic [AW-1:0]           mem_addr;
  logic [KEY_W-1:0]        mem_rdata;
  logic signed [KEY_W-1:0] rd_val;
  logic                    div_start;
  logic                    div_busy;
  logic [SPAN_W-1:0]       div_quot;
  logic [KEY_W-1:0]        div_num;
  logic [KEY_W-1:0]        div_den;
  logic [SPAN_W-1:0]       div_span;

  assign rd_val = signed'(mem_rdata);
  assign accept = in_valid && !in_stall;
  assign lo_in  = IDX_W'(range_low);
  assign hi_in  = IDX_W'(range_high);
  assign hi_cl  = (hi_in > HI_MAX) ? HI_MAX : hi_in;

  // differences are known nonnegative and below 2^32 when used
  assign div_num  = KEY_W'(key - a_lo);
  assign div_den  = KEY_W'(rd_val - a_lo);
  assign div_span = SPAN_W'(hi - lo);

  ise_ram #(
    .WIDTH (KEY_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (entry_value),
    .rdata (mem_rdata)
  );

  ise_muldiv u_muldiv (
    .clk    (clk),
    .rst    (rst),
    .start  (div_start),
    .num    (div_num),
    .span   (div_span),
    .den_in (div_den),
    .busy   (div_busy),
    .quot   (div_quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    key_next    = key;
    a_lo_next   = a_lo;
    lo_next     = lo;
    hi_next     = hi;
    pos_next    = pos;
    hit_next    = hit;
    probes_next = probes;
    in_stall    = (state != ST_IDLE);
    mem_we      = 1'b0;
    mem_addr    = AW'(unsigned'(lo));
    div_start   = 1'b0;
    out_load    = 1'b0;
    lo2         = lo;
    hi2         = hi;
    case (state)
      ST_IDLE: begin
        mem_addr = AW'(entry_index);
        if (accept) begin
          if (func == FUNC_WRITE) begin
            mem_we = (32'(entry_index) < DEPTH);
          end else begin
            key_next    = search_key;
            lo_next     = lo_in;
            hi_next     = hi_cl;
            hit_next    = 1'b0;
            probes_next = '0;
            state_next  = (lo_in > hi_cl) ? ST_FIN : ST_RD_LO;
          end
        end
      end
      ST_RD_LO: begin
        mem_addr   = AW'(unsigned'(lo));
        state_next = ST_RD_HI;
      end
      ST_RD_HI: begin
        mem_addr   = AW'(unsigned'(hi));
        a_lo_next  = rd_val;
        state_next = ST_CHK;
      end
      ST_CHK: begin
        if (key < a_lo || key > rd_val) begin
          state_next = ST_FIN;
        end else if (rd_val == a_lo) begin
          pos_next   = lo;
          state_next = ST_RD_POS;
        end else begin
          div_start  = 1'b1;
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (!div_busy) begin
          pos_next   = lo + IDX_W'(div_quot);
          state_next = ST_RD_POS;
        end
      end
      ST_RD_POS: begin
        mem_addr    = AW'(unsigned'(pos));
        probes_next = probes + CNT_W'(1);
        state_next  = ST_CMP;
      end
      ST_CMP: begin
        if (rd_val == key) begin
          hit_next   = 1'b1;
          state_next = ST_FIN;
        end else begin
          if (key < rd_val) begin
            hi2 = pos - IDX_W'(1);
          end else begin
            lo2 = pos + IDX_W'(1);
          end
          lo_next    = lo2;
          hi_next    = hi2;
          state_next = (lo2 > hi2) ? ST_FIN : ST_RD_LO;
        end
      end
      ST_FIN: begin
        if (!out_valid || !out_stall) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    key    <= key_next;
    a_lo   <= a_lo_next;
    lo     <= lo_next;
    hi     <= hi_next;
    pos    <= pos_next;
    hit    <= hit_next;
    probes <= probes_next;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_load || (out_valid && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      found       <= hit;
      found_index <= hit ? pos[IDXIN_W-1:0] : '0;
      probe_count <= probes;
    end
  end

endmodule
